// File: rtl/plane_bounce_reflect_unit_assert.svh
// Assertion macros used by the checker file of the plane bounce unit.
`ifndef PLANE_BOUNCE_REFLECT_UNIT_ASSERT_SVH
`define PLANE_BOUNCE_REFLECT_UNIT_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define PBR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pbr assertion failed");

// Clocked assertion that also holds across reset.
`define PBR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pbr assertion failed");

`endif

// File: rtl/pbr_pkg.sv
// Shared types and constants of the plane bounce reflect unit.
package pbr_pkg;

   localparam int CsrIdxW = 3;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_NX     = 3'd0,
      CSR_NY     = 3'd1,
      CSR_NZ     = 3'd2,
      CSR_OFFSET = 3'd3,
      CSR_GAIN   = 3'd4
   } csr_index_type;

   localparam logic signed [15:0] NxReset     = 16'sd0;
   localparam logic signed [15:0] NyReset     = 16'sd0;
   localparam logic signed [15:0] NzReset     = 16'sd16384;
   localparam logic signed [31:0] OffsetReset = 32'sd0;
   localparam logic [14:0]        GainReset   = 15'd16384;

   typedef logic signed [31:0] fix_type;

   typedef struct packed {
      fix_type     pos_x;
      fix_type     pos_y;
      fix_type     pos_z;
      fix_type     vel_x;
      fix_type     vel_y;
      fix_type     vel_z;
      logic [15:0] step_time;
      logic        particle_alive;
   } req_type;

   typedef struct packed {
      fix_type out_vel_x;
      fix_type out_vel_y;
      fix_type out_vel_z;
      logic    bounced;
   } rsp_type;

   typedef struct packed {
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic signed [15:0] nz;
      fix_type            offset;
      logic [14:0]        gain;
   } cfg_type;

   // predicted position, normal.v and velocity after the front stages
   typedef struct packed {
      logic signed [33:0] q_x;
      logic signed [33:0] q_y;
      logic signed [33:0] q_z;
      logic signed [35:0] dot;
      fix_type            vel_x;
      fix_type            vel_y;
      fix_type            vel_z;
      logic               live;
   } front_type;

   // reflected velocity before gain, plus the hit decision
   typedef struct packed {
      logic signed [39:0] r_x;
      logic signed [39:0] r_y;
      logic signed [39:0] r_z;
      fix_type            vel_x;
      fix_type            vel_y;
      fix_type            vel_z;
      logic               hit;
   } plane_type;

endpackage

// File: rtl/plane_bounce_reflect_unit.sv
// Top level of the plane bounce reflect unit: config registers and six-stage pipeline.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------------------
//   req      | in        | req_valid/req_ready  | req_data  (position, velocity, dt, alive)
//   rsp      | out       | rsp_valid/rsp_ready  | rsp_data  (velocity, bounced)
//   csr      | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One particle per cycle sustained unless rsp_ready stalls; six register stages,
// the first loaded at the req transfer edge. The stages are three multiplier rows
// (v*dt and n.v, n.q and n*dot, r*gain), each followed by a round/add stage.
// Synchronous active-high reset clears the stage valid bits and loads config defaults.
// Each stage holds while its successor is full and stalled; bubbles collapse, so
// req_ready stays high whenever any stage ahead has room.
// csr_ready is always high; writes to indexes beyond the register list are dropped.
module plane_bounce_reflect_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pbr_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pbr_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [pbr_pkg::CsrIdxW-1:0] csr_index,
   input  logic [31:0]                 csr_wdata
);
   import pbr_pkg::*;

   cfg_type   cfg_in, cfg_ff;

   // inter-module handshakes
   logic      front_valid, front_ready;
   front_type front_data;
   logic      plane_valid, plane_ready;
   plane_type plane_data;

   assign csr_ready = 1'b1;

   // config register file; writes are expected only while the pipe is idle
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_NX:     cfg_in.nx     = csr_wdata[15:0];
            CSR_NY:     cfg_in.ny     = csr_wdata[15:0];
            CSR_NZ:     cfg_in.nz     = csr_wdata[15:0];
            CSR_OFFSET: cfg_in.offset = csr_wdata;
            CSR_GAIN:   cfg_in.gain   = csr_wdata[14:0];
            default:    cfg_in        = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.nx     <= NxReset;
         cfg_ff.ny     <= NyReset;
         cfg_ff.nz     <= NzReset;
         cfg_ff.offset <= OffsetReset;
         cfg_ff.gain   <= GainReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // stages 1-2: q = p + v*dt, dot = n.v
   pbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_data  (front_data)
   );

   // stages 3-4: distance to plane, hit, unscaled reflection
   pbr_plane u_plane (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .cfg       (cfg_ff),
      .out_valid (plane_valid),
      .out_ready (plane_ready),
      .out_data  (plane_data)
   );

   // stages 5-6: gain, saturation, output register
   pbr_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (plane_valid),
      .in_ready  (plane_ready),
      .in_data   (plane_data),
      .cfg       (cfg_ff),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

endmodule

// File: rtl/pbr_front.sv
// Front stages: predicted position p+v*dt and rounded normal.v.
module pbr_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pbr_pkg::req_type    in_data,
   input  pbr_pkg::cfg_type    cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output pbr_pkg::front_type  out_data
);
   import pbr_pkg::*;

   logic signed [31:0] pos_a [3];
   logic signed [31:0] vel_a [3];
   logic signed [15:0] n_a [3];

   logic signed [48:0] vdt_in [3];
   logic signed [48:0] vdt_ff [3];
   logic signed [47:0] nv_in [3];
   logic signed [47:0] nv_ff [3];
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] vel_ff [3];
   logic               live_in, live_ff;

   logic signed [48:0] vdt_r [3];
   logic signed [32:0] step_a [3];
   logic signed [33:0] q_a [3];
   logic signed [49:0] nv_sum;

   front_type out_in, out_ff;
   logic      valid_a_ff, valid_b_ff;
   logic      ready_a, ready_b;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // stage A: products
   always_comb begin
      pos_a[0] = in_data.pos_x;
      pos_a[1] = in_data.pos_y;
      pos_a[2] = in_data.pos_z;
      vel_a[0] = in_data.vel_x;
      vel_a[1] = in_data.vel_y;
      vel_a[2] = in_data.vel_z;
      n_a[0]   = cfg.nx;
      n_a[1]   = cfg.ny;
      n_a[2]   = cfg.nz;
      for (int i = 0; i < 3; i++) begin
         vdt_in[i] = 49'(vel_a[i]) * 49'($signed({1'b0, in_data.step_time}));
         nv_in[i]  = 48'(n_a[i]) * 48'(vel_a[i]);
      end
      live_in = in_data.particle_alive &&
                ((in_data.vel_x != 32'sd0) || (in_data.vel_y != 32'sd0) ||
                 (in_data.vel_z != 32'sd0));
   end

   // stage B: round and sum
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         vdt_r[i]  = vdt_ff[i] + 49'sd32768;
         step_a[i] = 33'(vdt_r[i] >>> 16);
         q_a[i]    = 34'(pos_ff[i]) + 34'(step_a[i]);
      end
      nv_sum = 50'(nv_ff[0]) + 50'(nv_ff[1]) + 50'(nv_ff[2]) + 50'sd8192;
      out_in.q_x   = q_a[0];
      out_in.q_y   = q_a[1];
      out_in.q_z   = q_a[2];
      out_in.dot   = 36'(nv_sum >>> 14);
      out_in.vel_x = vel_ff[0];
      out_in.vel_y = vel_ff[1];
      out_in.vel_z = vel_ff[2];
      out_in.live  = live_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            vdt_ff[i] <= vdt_in[i];
            nv_ff[i]  <= nv_in[i];
            pos_ff[i] <= pos_a[i];
            vel_ff[i] <= vel_a[i];
         end
         live_ff <= live_in;
      end
      if (ready_b && valid_a_ff) out_ff <= out_in;
   end

   assign out_valid = valid_b_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/pbr_plane.sv
// Plane stages: signed distance, hit test and unscaled reflection.
module pbr_plane (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pbr_pkg::front_type  in_data,
   input  pbr_pkg::cfg_type    cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output pbr_pkg::plane_type  out_data
);
   import pbr_pkg::*;

   logic signed [33:0] q_a [3];
   logic signed [15:0] n_a [3];
   logic signed [31:0] vel_a [3];

   logic signed [49:0] nq_in [3];
   logic signed [49:0] nq_ff [3];
   logic signed [51:0] nd_in [3];
   logic signed [51:0] nd_ff [3];
   logic signed [31:0] vel_ff [3];
   logic               live_ff;

   logic signed [52:0] plane_dist;
   logic signed [53:0] refl [3];
   logic signed [39:0] r_a [3];

   plane_type out_in, out_ff;
   logic      valid_a_ff, valid_b_ff;
   logic      ready_a, ready_b;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // stage A: n.q terms and n*dot terms
   always_comb begin
      q_a[0]   = in_data.q_x;
      q_a[1]   = in_data.q_y;
      q_a[2]   = in_data.q_z;
      vel_a[0] = in_data.vel_x;
      vel_a[1] = in_data.vel_y;
      vel_a[2] = in_data.vel_z;
      n_a[0]   = cfg.nx;
      n_a[1]   = cfg.ny;
      n_a[2]   = cfg.nz;
      for (int i = 0; i < 3; i++) begin
         nq_in[i] = 50'(n_a[i]) * 50'(q_a[i]);
         nd_in[i] = 52'(n_a[i]) * 52'(in_data.dot);
      end
   end

   // stage B: distance sum, hit, r = round(2*n*dot - v)
   always_comb begin
      plane_dist = 53'(nq_ff[0]) + 53'(nq_ff[1]) + 53'(nq_ff[2]) +
                   (53'(cfg.offset) <<< 14);
      for (int i = 0; i < 3; i++) begin
         refl[i] = (54'(nd_ff[i]) <<< 1) - (54'(vel_ff[i]) <<< 14) + 54'sd8192;
         r_a[i]  = 40'(refl[i] >>> 14);
      end
      out_in.r_x   = r_a[0];
      out_in.r_y   = r_a[1];
      out_in.r_z   = r_a[2];
      out_in.vel_x = vel_ff[0];
      out_in.vel_y = vel_ff[1];
      out_in.vel_z = vel_ff[2];
      out_in.hit   = live_ff && (plane_dist <= 53'sd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            nq_ff[i]  <= nq_in[i];
            nd_ff[i]  <= nd_in[i];
            vel_ff[i] <= vel_a[i];
         end
         live_ff <= in_data.live;
      end
      if (ready_b && valid_a_ff) out_ff <= out_in;
   end

   assign out_valid = valid_b_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/pbr_scale.sv
// Scale stages: restitution gain, negate, round, saturate, select.
module pbr_scale (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  pbr_pkg::plane_type  in_data,
   input  pbr_pkg::cfg_type    cfg,
   output logic                out_valid,
   input  logic                out_ready,
   output pbr_pkg::rsp_type    out_data
);
   import pbr_pkg::*;

   localparam logic signed [42:0] SatMax = 43'sd2147483647;
   localparam logic signed [42:0] SatMin = -43'sd2147483648;

   logic signed [39:0] r_a [3];
   logic signed [31:0] vel_a [3];

   logic signed [55:0] rg_in [3];
   logic signed [55:0] rg_ff [3];
   logic signed [31:0] vel_ff [3];
   logic               hit_ff;

   logic signed [56:0] neg [3];
   logic signed [42:0] scaled [3];
   logic signed [31:0] res [3];

   rsp_type out_in, out_ff;
   logic    valid_a_ff, valid_b_ff;
   logic    ready_a, ready_b;

   assign ready_b  = !valid_b_ff || out_ready;
   assign ready_a  = !valid_a_ff || ready_b;
   assign in_ready = ready_a;

   // stage A: r * gain
   always_comb begin
      r_a[0]   = in_data.r_x;
      r_a[1]   = in_data.r_y;
      r_a[2]   = in_data.r_z;
      vel_a[0] = in_data.vel_x;
      vel_a[1] = in_data.vel_y;
      vel_a[2] = in_data.vel_z;
      for (int i = 0; i < 3; i++) begin
         rg_in[i] = 56'(r_a[i]) * 56'($signed({1'b0, cfg.gain}));
      end
   end

   // stage B: round(-(r*gain)), clamp, pass-through when no hit
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg[i]    = 57'sd8192 - 57'(rg_ff[i]);
         scaled[i] = 43'(neg[i] >>> 14);
         if (scaled[i] > SatMax) begin
            res[i] = 32'(SatMax);
         end else if (scaled[i] < SatMin) begin
            res[i] = 32'(SatMin);
         end else begin
            res[i] = 32'(scaled[i]);
         end
      end
      out_in.out_vel_x = hit_ff ? res[0] : vel_ff[0];
      out_in.out_vel_y = hit_ff ? res[1] : vel_ff[1];
      out_in.out_vel_z = hit_ff ? res[2] : vel_ff[2];
      out_in.bounced   = hit_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         if (ready_a) valid_a_ff <= in_valid;
         if (ready_b) valid_b_ff <= valid_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready_a && in_valid) begin
         for (int i = 0; i < 3; i++) begin
            rg_ff[i]  <= rg_in[i];
            vel_ff[i] <= vel_a[i];
         end
         hit_ff <= in_data.hit;
      end
      if (ready_b && valid_a_ff) out_ff <= out_in;
   end

   assign out_valid = valid_b_ff;
   assign out_data  = out_ff;

endmodule

// File: rtl/pbr_checker.sv
// Port-level assertions for the plane bounce reflect unit, with bind.
`include "plane_bounce_reflect_unit_assert.svh"

module pbr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pbr_pkg::rsp_type rsp_data,
   input logic             csr_ready
);

   // a stalled result keeps its valid and payload
   `PBR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))

   // empty output stage means the whole ready chain is open
   `PBR_ASSERT(a_empty_ready, clock, reset, !rsp_valid |-> req_ready)

   // reset flushes the pipe
   `PBR_ASSERT_ALWAYS(a_reset_flush, clock, reset |=> !rsp_valid)

   // register writes never stall
   `PBR_ASSERT_ALWAYS(a_csr_ready, clock, csr_ready)

endmodule

bind plane_bounce_reflect_unit pbr_checker u_pbr_checker (.*);
